// ----- src/lru_stack_tag_set_unit_defines.svh -----
// ----------------------------------------------------------------------------
// LRU stack tag set unit: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_STACK_TAG_SET_UNIT_DEFINES_SVH
`define LRU_STACK_TAG_SET_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LSTU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru stack tag set unit: assertion failed");

// Next-cycle implication.
`define LSTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru stack tag set unit: assertion failed");

`endif

// ----- src/lstu_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU stack tag set package
// Action codes, field widths, defaults and the command bundle to the stack.
// ----------------------------------------------------------------------------
`default_nettype none

package lstu_pkg;

    localparam int ACT_W      = 2;
    localparam int TAG_IN_W   = 20;
    localparam int POS_IN_W   = 3;

    localparam int ASSOC_DEF    = 8;
    localparam int TAG_BITS_DEF = 20;

    localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_HEAD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TAIL    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_INSTALL = 2'd3;

    typedef struct packed {
        logic                en;
        logic [ACT_W-1:0]    action;
        logic [POS_IN_W-1:0] position;
        logic                pos_ok;
        logic                valid_in;
    } t_stk_cmd;

endpackage

`default_nettype wire

// ----- src/lstu_lookup.sv -----
// ----------------------------------------------------------------------------
// LRU stack lookup
// Parallel tag compare over all positions, first match from the MRU end.
// ----------------------------------------------------------------------------
`default_nettype none

module lstu_lookup
    import lstu_pkg::*;
#(
    parameter int ASSOC   = ASSOC_DEF,
    parameter int STORE_W = TAG_BITS_DEF
) (
    input  wire logic [ASSOC-1:0][STORE_W-1:0] i_tags,
    input  wire logic [ASSOC-1:0]              i_valids,
    input  wire logic [STORE_W-1:0]            i_tag,
    output logic                               o_hit,
    output logic [POS_IN_W-1:0]                o_hit_position
);

    // Scan from the LRU end down so the match nearest the MRU end wins.
    always_comb begin
        o_hit          = 1'b0;
        o_hit_position = '0;
        for (int i = ASSOC - 1; i >= 0; i--) begin
            if (i_valids[i] && (i_tags[i] == i_tag)) begin
                o_hit          = 1'b1;
                o_hit_position = POS_IN_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/lstu_stack.sv -----
// ----------------------------------------------------------------------------
// LRU stack storage
// Recency stack registers with move-to-head, move-to-tail and install.
// ----------------------------------------------------------------------------
`default_nettype none

module lstu_stack
    import lstu_pkg::*;
#(
    parameter int ASSOC   = ASSOC_DEF,
    parameter int STORE_W = TAG_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_stk_cmd                      i_cmd,
    input  wire logic [STORE_W-1:0]            i_tag,
    output logic [ASSOC-1:0][STORE_W-1:0]      o_tags,
    output logic [ASSOC-1:0]                   o_valids,
    output logic [STORE_W-1:0]                 o_tail_tag,
    output logic                               o_tail_valid
);

    localparam int IDX_W = (ASSOC > 1) ? $clog2(ASSOC) : 1;

    logic [ASSOC-1:0][STORE_W-1:0] r_tags;
    logic [ASSOC-1:0][STORE_W-1:0] n_tags;
    logic [ASSOC-1:0]              r_valids;
    logic [ASSOC-1:0]              n_valids;
    logic [IDX_W-1:0]              pos_idx;
    logic [STORE_W-1:0]            sel_tag;
    logic                          sel_valid;

    assign pos_idx   = IDX_W'(i_cmd.position);
    assign sel_tag   = r_tags[pos_idx];
    assign sel_valid = r_valids[pos_idx];

    always_comb begin
        n_tags   = r_tags;
        n_valids = r_valids;
        if (i_cmd.en && i_cmd.pos_ok) begin
            unique case (i_cmd.action)
                ACT_LOOKUP: begin
                end
                ACT_HEAD: begin
                    // Shift younger entries down one, drop the selected one at the head.
                    for (int i = 1; i < ASSOC; i++) begin
                        if (i <= int'(i_cmd.position)) begin
                            n_tags[i]   = r_tags[i-1];
                            n_valids[i] = r_valids[i-1];
                        end
                    end
                    n_tags[0]   = sel_tag;
                    n_valids[0] = sel_valid;
                end
                ACT_TAIL: begin
                    // Shift older entries up one, sink the selected one to the tail.
                    for (int i = 0; i < ASSOC - 1; i++) begin
                        if (i >= int'(i_cmd.position)) begin
                            n_tags[i]   = r_tags[i+1];
                            n_valids[i] = r_valids[i+1];
                        end
                    end
                    n_tags[ASSOC-1]   = sel_tag;
                    n_valids[ASSOC-1] = sel_valid;
                end
                ACT_INSTALL: begin
                    n_tags[pos_idx]   = i_tag;
                    n_valids[pos_idx] = i_cmd.valid_in;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags   <= '0;
            r_valids <= '0;
        end else begin
            r_tags   <= n_tags;
            r_valids <= n_valids;
        end
    end

    assign o_tags       = r_tags;
    assign o_valids     = r_valids;
    assign o_tail_tag   = n_tags[ASSOC-1];
    assign o_tail_valid = n_valids[ASSOC-1];

endmodule

`default_nettype wire

// ----- src/lru_stack_tag_set_unit.sv -----
// ----------------------------------------------------------------------------
// LRU stack tag set unit
// One cache set kept as a true-LRU recency stack with lookup, move and install.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | to block  | i_in_valid / o_in_stall | i_action i_lookup_tag i_position
//           |           |                        | i_valid_in
//   out     | from block| o_out_valid / i_out_stall| o_hit o_hit_position o_tail_tag
//           |           |                        | o_tail_valid
//
// One transaction per cycle sustained while the output does not stall. An
// accepted item sits in the input register; when it advances, the compare and
// stack update run and load the result register, from which the result leaves.
// Every input transaction produces exactly one output transaction.
// Reset (synchronous, i_rst_n low) empties both registers and clears the stack
// to all invalid entries with zero tags.
// A stall on the output holds the result and the item in the input register;
// o_in_stall rises only while the input register holds an item that cannot move.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_stack_tag_set_unit
    import lstu_pkg::*;
#(
    parameter int ASSOC    = ASSOC_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [TAG_IN_W-1:0] i_lookup_tag,
    input  wire logic [POS_IN_W-1:0] i_position,
    input  wire logic                i_valid_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_hit,
    output logic [POS_IN_W-1:0]      o_hit_position,
    output logic [TAG_IN_W-1:0]      o_tail_tag,
    output logic                     o_tail_valid
);

`include "lru_stack_tag_set_unit_defines.svh"

    // Tags arrive on a fixed-width port, so no stored tag bit can exceed it.
    localparam int STORE_W = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
    localparam int IDX_W   = (ASSOC > 1) ? $clog2(ASSOC) : 1;

    // Input register
    logic                r_in_full;
    logic [ACT_W-1:0]    r_in_action;
    logic [STORE_W-1:0]  r_in_tag;
    logic [POS_IN_W-1:0] r_in_position;
    logic                r_in_valid_in;

    // Result register
    logic                r_out_valid;
    logic                r_hit;
    logic [POS_IN_W-1:0] r_hit_position;
    logic [STORE_W-1:0]  r_tail_tag;
    logic                r_tail_valid;

    logic                          w_out_free;
    logic                          w_adv;
    logic                          w_in_take;
    logic                          w_pos_ok;
    t_stk_cmd                      w_cmd;
    logic [ASSOC-1:0][STORE_W-1:0] w_tags;
    logic [ASSOC-1:0]              w_valids;
    logic [STORE_W-1:0]            w_tail_tag;
    logic                          w_tail_valid;
    logic                          w_hit;
    logic [POS_IN_W-1:0]           w_hit_position;
    logic                          n_hit;
    logic [POS_IN_W-1:0]           n_hit_position;
    logic [IDX_W-1:0]              w_pos_idx;

    // Advance the held item when the result register is empty or draining.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_full && w_out_free;
    assign o_in_stall = r_in_full && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Moves and installs past the last way leave the stack alone.
    assign w_pos_ok   = (32'(r_in_position) < 32'(ASSOC));
    assign w_pos_idx  = IDX_W'(r_in_position);

    always_comb begin
        w_cmd          = '0;
        w_cmd.en       = w_adv;
        w_cmd.action   = r_in_action;
        w_cmd.position = r_in_position;
        w_cmd.pos_ok   = w_pos_ok;
        w_cmd.valid_in = r_in_valid_in;
    end

    lstu_stack #(
        .ASSOC   (ASSOC),
        .STORE_W (STORE_W)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_tag        (r_in_tag),
        .o_tags       (w_tags),
        .o_valids     (w_valids),
        .o_tail_tag   (w_tail_tag),
        .o_tail_valid (w_tail_valid)
    );

    lstu_lookup #(
        .ASSOC   (ASSOC),
        .STORE_W (STORE_W)
    ) u_lookup (
        .i_tags         (w_tags),
        .i_valids       (w_valids),
        .i_tag          (r_in_tag),
        .o_hit          (w_hit),
        .o_hit_position (w_hit_position)
    );

    // Report hits for lookups only; other actions and misses return zero hit and position.
    assign n_hit          = (r_in_action == ACT_LOOKUP) && w_hit;
    assign n_hit_position = n_hit ? w_hit_position : '0;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_full <= 1'b1;
            end else if (w_adv) begin
                r_in_full <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: input fields load on capture, result fields on advance; hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action   <= i_action;
            r_in_tag      <= STORE_W'(i_lookup_tag);
            r_in_position <= i_position;
            r_in_valid_in <= i_valid_in;
        end
        if (w_adv) begin
            r_hit          <= n_hit;
            r_hit_position <= n_hit_position;
            r_tail_tag     <= w_tail_tag;
            r_tail_valid   <= w_tail_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_hit_position = r_hit_position;
    assign o_tail_tag     = TAG_IN_W'(r_tail_tag);
    assign o_tail_valid   = r_tail_valid;

    // Hits come from lookups only.
    `LSTU_ASSERT_NEXT(a_hit_lookup_only, w_adv && (r_in_action != ACT_LOOKUP), !r_hit)
    // Moves reorder the stack but never change the number of valid entries.
    `LSTU_ASSERT_NEXT(a_move_keeps_count,
                      w_adv && ((r_in_action == ACT_HEAD) || (r_in_action == ACT_TAIL)),
                      $countones(w_valids) == $past($countones(w_valids)))
    // A lift in range puts the selected tag at the head.
    `LSTU_ASSERT_NEXT(a_head_lift,
                      w_adv && (r_in_action == ACT_HEAD) && w_pos_ok,
                      w_tags[0] == $past(w_tags[w_pos_idx]))
    // Back-pressure only while an item is held.
    `LSTU_ASSERT_IMPL(a_stall_needs_item, o_in_stall, r_in_full && r_out_valid)

endmodule

`default_nettype wire

// ----- tb/tb_lru_stack_tag_set_unit.sv -----
// ----------------------------------------------------------------------------
// LRU stack tag set unit: self-checking testbench
// Keeps its own recency stack, predicts each result from the transactions the
// block accepts, and checks every output transaction in order. Directed cases
// come first, then random traffic under several idle and stall mixes and one
// long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_stack_tag_set_unit;
    import lstu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = ASSOC_DEF;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PER_MIX = 300;
    localparam int PRESSURE_ITEMS = 48;
    localparam int POOL_SIZE      = 12;

    localparam logic [TAG_IN_W-1:0] TAG_MASK = TAG_IN_W'((64'd1 << TAG_BITS_DEF) - 1);

    // One stack slot: tag plus valid bit.
    typedef struct packed {
        logic [TAG_IN_W-1:0] tag;
        logic                valid;
    } t_way;

    // One output transaction: hit report plus the current replacement victim.
    typedef struct packed {
        logic                hit;
        logic [POS_IN_W-1:0] hit_pos;
        logic [TAG_IN_W-1:0] tail_tag;
        logic                tail_valid;
    } t_victim_report;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ACT_W-1:0]    i_action;
    logic [TAG_IN_W-1:0] i_lookup_tag;
    logic [POS_IN_W-1:0] i_position;
    logic                i_valid_in;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_hit;
    logic [POS_IN_W-1:0] o_hit_position;
    logic [TAG_IN_W-1:0] o_tail_tag;
    logic                o_tail_valid;

    lru_stack_tag_set_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_lookup_tag   (i_lookup_tag),
        .i_position     (i_position),
        .i_valid_in     (i_valid_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_hit_position (o_hit_position),
        .o_tail_tag     (o_tail_tag),
        .o_tail_valid   (o_tail_valid)
    );

    // 4 ns period clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    t_way                recency [STACK_DEPTH];   // predicted stack, MRU at 0
    t_victim_report      victim_queue [$];        // predicted results in order
    logic [TAG_IN_W-1:0] tag_pool [POOL_SIZE];    // tags reused so lookups hit

    int send_idle_pct   = 0;   // chance per cycle the sender stays idle
    int recv_stall_pct  = 0;   // chance per cycle the receiver stalls
    int holds_requested = 0;   // written by the tests only
    int holds_started   = 0;   // written by the receiver only
    int error_count     = 0;
    int accepted_in     = 0;
    int checked_out     = 0;
    int hit_count       = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------------
    // Predictor: apply one transaction to the stack and return its result.
    // ------------------------------------------------------------------------
    function automatic t_victim_report apply_action(input logic [ACT_W-1:0]    act,
                                                    input logic [TAG_IN_W-1:0] tag,
                                                    input logic [POS_IN_W-1:0] pos,
                                                    input logic                vin);
        t_victim_report rep;
        t_way           moved;
        logic [TAG_IN_W-1:0] key;
        bit             found;
        int             i;
        rep   = '0;
        found = 1'b0;
        key   = tag & TAG_MASK;
        if (act == ACT_LOOKUP) begin
            // Search from the MRU end; the first valid match wins.
            for (i = 0; i < STACK_DEPTH; i++) begin
                if (!found && recency[i].valid && recency[i].tag == key) begin
                    found       = 1'b1;
                    rep.hit     = 1'b1;
                    rep.hit_pos = POS_IN_W'(i);
                end
            end
        end else if (int'(pos) < STACK_DEPTH) begin
            case (act)
                ACT_HEAD: begin
                    // Lift to position 0, push the younger entries down.
                    moved = recency[pos];
                    for (i = int'(pos); i > 0; i--) recency[i] = recency[i-1];
                    recency[0] = moved;
                end
                ACT_TAIL: begin
                    // Sink to the last position, pull the older entries up.
                    moved = recency[pos];
                    for (i = int'(pos); i + 1 < STACK_DEPTH; i++) recency[i] = recency[i+1];
                    recency[STACK_DEPTH-1] = moved;
                end
                ACT_INSTALL: begin
                    recency[pos].tag   = key;
                    recency[pos].valid = vin;
                end
                default: begin
                end
            endcase
        end
        rep.tail_tag   = recency[STACK_DEPTH-1].tag;
        rep.tail_valid = recency[STACK_DEPTH-1].valid;
        return rep;
    endfunction

    task automatic report_field(input string name, input logic [TAG_IN_W-1:0] exp_val,
                                input logic [TAG_IN_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor and checker: at each rising edge check the output transaction
    // first, then predict the input transaction. A result can never belong to
    // an item accepted at the same edge, so this order is safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_victim_report exp_rep;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (victim_queue.size() == 0) begin
                    $display("%0t: unexpected result, hit %0b pos %0d tail 0x%0h/%0b",
                             $time, o_hit, o_hit_position, o_tail_tag, o_tail_valid);
                    error_count++;
                end else begin
                    exp_rep = victim_queue.pop_front();
                    report_field("hit", TAG_IN_W'(exp_rep.hit), TAG_IN_W'(o_hit));
                    report_field("hit_position", TAG_IN_W'(exp_rep.hit_pos),
                                 TAG_IN_W'(o_hit_position));
                    report_field("tail_tag", exp_rep.tail_tag, o_tail_tag);
                    report_field("tail_valid", TAG_IN_W'(exp_rep.tail_valid),
                                 TAG_IN_W'(o_tail_valid));
                    checked_out++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                exp_rep = apply_action(i_action, i_lookup_tag, i_position, i_valid_in);
                if (exp_rep.hit) hit_count++;
                victim_queue.push_back(exp_rep);
                accepted_in++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a counted hold-off when a test asks for it.
    // ------------------------------------------------------------------------
    initial begin : out_side
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_started != holds_requested) begin
                holds_started++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: idle at random, then offer one transaction and hold it until
    // the block takes it.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [ACT_W-1:0]    act,
                             input logic [TAG_IN_W-1:0] tag,
                             input logic [POS_IN_W-1:0] pos,
                             input logic                vin);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_lookup_tag <= tag;
        i_position   <= pos;
        i_valid_in   <= vin;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (victim_queue.size() != 0) @(posedge i_clk);
    endtask

    // Draw a tag: mostly from the pool so lookups find something, else any.
    function automatic logic [TAG_IN_W-1:0] pick_tag();
        if ($urandom_range(99) < 75) return tag_pool[$urandom_range(POOL_SIZE-1)];
        return TAG_IN_W'($urandom);
    endfunction

    // Weighted random transaction: lookups most often, moves and installs next.
    task automatic send_random_item();
        int sel;
        logic [ACT_W-1:0] act;
        sel = $urandom_range(9);
        if (sel < 4)      act = ACT_LOOKUP;
        else if (sel < 6) act = ACT_HEAD;
        else if (sel < 8) act = ACT_TAIL;
        else              act = ACT_INSTALL;
        send_item(act, pick_tag(), POS_IN_W'($urandom_range(STACK_DEPTH-1)),
                  ($urandom_range(99) < 85));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // After reset every entry is invalid with tag zero: even tag 0 must miss.
    task automatic test_reset_state();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(ACT_LOOKUP, '0, '0, 1'b0);
        send_item(ACT_LOOKUP, '1, '0, 1'b0);
        wait_drained();
    endtask

    // Fill the set, hit both ends, miss, duplicates, and an invalid match.
    task automatic test_install_lookup();
        int p;
        send_item(ACT_INSTALL, '1, 3'd0, 1'b1);
        for (p = 1; p < STACK_DEPTH - 1; p++)
            send_item(ACT_INSTALL, TAG_IN_W'(20'h1_0000 * p + p), POS_IN_W'(p), 1'b1);
        send_item(ACT_INSTALL, '0, POS_IN_W'(STACK_DEPTH-1), 1'b1);
        send_item(ACT_LOOKUP, '0, '0, 1'b0);
        send_item(ACT_LOOKUP, '1, '0, 1'b1);
        send_item(ACT_LOOKUP, 20'h5A5A5, '0, 1'b0);
        // Duplicate tag: the copy nearer the MRU end must be reported.
        send_item(ACT_INSTALL, 20'h2_0002, 3'd5, 1'b1);
        send_item(ACT_LOOKUP, 20'h2_0002, '0, 1'b0);
        // Invalidate the nearer copy: the lookup must skip it.
        send_item(ACT_INSTALL, 20'h2_0002, 3'd2, 1'b0);
        send_item(ACT_LOOKUP, 20'h2_0002, '0, 1'b0);
        wait_drained();
    endtask

    // Head to head and tail to tail leave the stack alone; the rest rotate.
    task automatic test_moves();
        send_item(ACT_HEAD, '0, 3'd0, 1'b0);
        send_item(ACT_TAIL, '0, POS_IN_W'(STACK_DEPTH-1), 1'b0);
        send_item(ACT_HEAD, '0, POS_IN_W'(STACK_DEPTH-1), 1'b0);
        send_item(ACT_TAIL, '0, 3'd0, 1'b0);
        send_item(ACT_HEAD, '0, 3'd4, 1'b1);
        send_item(ACT_TAIL, '1, 3'd3, 1'b1);
        send_item(ACT_LOOKUP, '0, '0, 1'b0);
        send_item(ACT_LOOKUP, '1, '0, 1'b0);
        wait_drained();
    endtask

    // Random traffic under one idle and stall mix.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < RANDOM_PER_MIX; n++) send_random_item();
        wait_drained();
    endtask

    // Hold the output for a long stretch while the sender keeps offering,
    // so the pipeline fills and the block stalls its input.
    task automatic test_backpressure();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_requested++;
        for (n = 0; n < PRESSURE_ITEMS; n++) send_random_item();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int k;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = ACT_LOOKUP;
        i_lookup_tag = '0;
        i_position   = '0;
        i_valid_in   = 1'b0;
        for (k = 0; k < STACK_DEPTH; k++) recency[k] = '0;
        // Keep both extremes in the pool so the edge tags get hit too.
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) tag_pool[k] = TAG_IN_W'($urandom);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_install_lookup();
        test_moves();
        test_random_traffic(0, 0);
        test_random_traffic(77, 0);
        test_random_traffic(0, 77);
        test_random_traffic(33, 33);
        test_backpressure();

        // Let the pipeline settle so a stray late result still gets caught.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d transactions in, %0d results checked, %0d lookup hits,",
                 accepted_in, checked_out, hit_count);
        $display("over four idle/stall mixes and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (error_count == 0 && victim_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
